// ----- rtl/envc_pkg.sv -----
// ---------------------------------------------------------------------------
// envc_pkg
// shared types, register indexes and constants of the sensor compensation
// ---------------------------------------------------------------------------
package envc_pkg;

    localparam int RAW_T_W  = 20;
    localparam int RAW_H_W  = 16;
    localparam int TEMP_W   = 16;
    localparam int HUM_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int AXIS_IN_W  = 40;
    localparam int AXIS_OUT_W = 40;

    // reciprocal of 100 for unsigned 32-bit dividends, exact over the whole range
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int          DIV100_SHIFT = 37;
    localparam int          DIV100_Q_W   = 64 - DIV100_SHIFT;

    localparam logic signed [31:0] TEMP_ROUND = 32'sd128;
    localparam logic signed [31:0] HUM_OFFSET = 32'sd16384;
    localparam logic signed [31:0] HUM_SCALE  = 32'sd1000;
    localparam logic signed [31:0] TEMP_MAX   = 32'sd32767;
    localparam logic signed [31:0] TEMP_MIN   = -32'sd32768;
    localparam logic signed [31:0] HUM_MAX    = 32'sd100000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_CAL_ONE   = 3'd0,
        CFG_TEMP_CAL_TWO   = 3'd1,
        CFG_TEMP_CAL_THREE = 3'd2,
        CFG_HUM_CAL_ONE    = 3'd3,
        CFG_HUM_CAL_TWO    = 3'd4,
        CFG_HUM_CAL_REST   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [7:0]  t3;
        logic [11:0] h1;
        logic [11:0] h2;
        logic [39:0] hrest;   // h3 h4 h5 h6 h7 from the lowest byte up
    } t_cal;

endpackage

// ----- rtl/envc_div100.sv -----
// ---------------------------------------------------------------------------
// envc_div100
// three-stage signed division by 100, truncating toward zero
// ---------------------------------------------------------------------------
module envc_div100 (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_dividend,
    output logic signed [31:0] o_quotient
);
    import envc_pkg::*;

    logic               r_sign_a;
    logic [31:0]        r_mag;
    logic               r_sign_b;
    logic [63:0]        r_prod;
    logic signed [31:0] r_q;
    logic [31:0]        n_mag;
    logic [DIV100_Q_W-1:0] q_mag;

    assign n_mag = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
    assign q_mag = r_prod[63:DIV100_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sign_a <= i_dividend[31];
            r_mag    <= n_mag;
            r_sign_b <= r_sign_a;
            r_prod   <= {32'd0, r_mag} * {32'd0, DIV100_MAGIC};
            r_q      <= r_sign_b ? (32'sd0 - $signed({{(32-DIV100_Q_W){1'b0}}, q_mag}))
                                 : $signed({{(32-DIV100_Q_W){1'b0}}, q_mag});
        end
    end

    assign o_quotient = r_q;

endmodule

// ----- rtl/envc_temp.sv -----
// ---------------------------------------------------------------------------
// envc_temp
// five-stage temperature compensation, raw humidity carried alongside
// ---------------------------------------------------------------------------
module envc_temp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [19:0]          i_raw_t,
    input  logic [15:0]          i_raw_h,
    input  envc_pkg::t_cal       i_cal,
    output logic                 o_valid,
    output logic signed [31:0]   o_tc,
    output logic [15:0]          o_raw_h
);
    import envc_pkg::*;

    logic [4:0]         r_v;
    logic [15:0]        r_rh [5];
    logic signed [31:0] r_a, r_p1, r_p2, r_b, r_p3, r_fine, r_tc;
    logic signed [31:0] n_a, half, t2x, t3x16;

    assign n_a   = $signed({15'd0, i_raw_t[19:3]}) - $signed({15'd0, i_cal.t1, 1'b0});
    assign half  = r_a >>> 1;
    assign t2x   = $signed({{16{i_cal.t2[15]}}, i_cal.t2});
    assign t3x16 = $signed({{20{i_cal.t3[7]}}, i_cal.t3, 4'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rh[0] <= i_raw_h;
            r_rh[1] <= r_rh[0];
            r_rh[2] <= r_rh[1];
            r_rh[3] <= r_rh[2];
            r_rh[4] <= r_rh[3];
            r_a     <= n_a;
            r_p1    <= r_a * t2x;
            r_p2    <= half * half;
            r_b     <= r_p1 >>> 11;
            r_p3    <= (r_p2 >>> 12) * t3x16;
            r_fine  <= r_b + (r_p3 >>> 14);
            r_tc    <= (r_fine + (r_fine <<< 2) + TEMP_ROUND) >>> 8;
        end
    end

    assign o_valid = r_v[4];
    assign o_tc    = r_tc;
    assign o_raw_h = r_rh[4];

endmodule

// ----- rtl/envc_hum.sv -----
// ---------------------------------------------------------------------------
// envc_hum
// fifteen-stage humidity compensation with temperature saturation
// ---------------------------------------------------------------------------
module envc_hum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [31:0]   i_tc,
    input  logic [15:0]          i_raw_h,
    input  envc_pkg::t_cal       i_cal,
    output logic                 o_valid,
    output logic [15:0]          o_temperature_centi,
    output logic [16:0]          o_humidity_milli
);
    import envc_pkg::*;

    typedef struct packed {
        logic [31:0] q3;
        logic [31:0] q4;
        logic [31:0] q7;
        logic [15:0] rh;
        logic [15:0] tout;
    } t_carry;

    logic [14:0]        r_v;
    logic signed [31:0] h2x, h3x, h4x, h5x, h7x, h1x16, h6x128;
    logic [15:0]        n_tout;

    // stage 6 products and temperature saturation
    logic signed [31:0] r6_m3, r6_m4, r6_m5, r6_m7, r6_ts;
    logic [15:0]        r6_rh, r6_tout;
    // stages 7 to 9, alongside the first dividers
    logic signed [31:0] r7_ts, r8_ts, r9_ts;
    logic [15:0]        r7_rh, r8_rh, r9_rh, r7_tout, r8_tout, r9_tout;
    logic signed [31:0] q3, q4, q5, q7, q55;
    // stage 10 and the carry over the second divider
    logic signed [31:0] r10_p;
    t_carry             r10_c, r11_c, r12_c, r13_c;
    // stages 14 to 20
    logic signed [31:0] r14_d1, r14_d2, r14_d4;
    logic signed [31:0] r15_d1, r15_d4, r15_d2m;
    logic signed [31:0] r16_d3, r16_d4;
    logic signed [31:0] r17_d3, r17_d4, r17_d5m;
    logic signed [31:0] r18_d3, r18_d6m;
    logic signed [31:0] r19_sum, r20_hm;
    logic [15:0]        r14_tout, r15_tout, r16_tout, r17_tout, r18_tout, r19_tout,
                        r20_tout;
    logic signed [31:0] e17, hv;

    assign h1x16  = $signed({16'd0, i_cal.h1, 4'd0});
    assign h2x    = $signed({20'd0, i_cal.h2});
    assign h3x    = $signed({{24{i_cal.hrest[7]}},  i_cal.hrest[7:0]});
    assign h4x    = $signed({{24{i_cal.hrest[15]}}, i_cal.hrest[15:8]});
    assign h5x    = $signed({{24{i_cal.hrest[23]}}, i_cal.hrest[23:16]});
    assign h6x128 = $signed({17'd0, i_cal.hrest[31:24], 7'd0});
    assign h7x    = $signed({{24{i_cal.hrest[39]}}, i_cal.hrest[39:32]});

    always_comb begin
        if (i_tc > TEMP_MAX) begin
            n_tout = TEMP_MAX[15:0];
        end else if (i_tc < TEMP_MIN) begin
            n_tout = TEMP_MIN[15:0];
        end else begin
            n_tout = i_tc[15:0];
        end
    end

    envc_div100 u_div_h3 (.i_clk(i_clk), .i_en(i_en), .i_dividend(r6_m3), .o_quotient(q3));
    envc_div100 u_div_h4 (.i_clk(i_clk), .i_en(i_en), .i_dividend(r6_m4), .o_quotient(q4));
    envc_div100 u_div_h5 (.i_clk(i_clk), .i_en(i_en), .i_dividend(r6_m5), .o_quotient(q5));
    envc_div100 u_div_h7 (.i_clk(i_clk), .i_en(i_en), .i_dividend(r6_m7), .o_quotient(q7));
    envc_div100 u_div_sq (.i_clk(i_clk), .i_en(i_en), .i_dividend(r10_p >>> 6),
                          .o_quotient(q55));

    assign e17 = r16_d3 >>> 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[13:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_m3   <= i_tc * h3x;
            r6_m4   <= i_tc * h4x;
            r6_m5   <= i_tc * h5x;
            r6_m7   <= i_tc * h7x;
            r6_ts   <= i_tc;
            r6_rh   <= i_raw_h;
            r6_tout <= n_tout;

            r7_ts   <= r6_ts;
            r8_ts   <= r7_ts;
            r9_ts   <= r8_ts;
            r7_rh   <= r6_rh;
            r8_rh   <= r7_rh;
            r9_rh   <= r8_rh;
            r7_tout <= r6_tout;
            r8_tout <= r7_tout;
            r9_tout <= r8_tout;

            r10_p      <= r9_ts * q5;
            r10_c.q3   <= q3;
            r10_c.q4   <= q4;
            r10_c.q7   <= q7;
            r10_c.rh   <= r9_rh;
            r10_c.tout <= r9_tout;
            r11_c      <= r10_c;
            r12_c      <= r11_c;
            r13_c      <= r12_c;

            r14_d1   <= $signed({16'd0, r13_c.rh}) - h1x16 - ($signed(r13_c.q3) >>> 1);
            r14_d2   <= $signed(r13_c.q4) + q55 + HUM_OFFSET;
            r14_d4   <= (h6x128 + $signed(r13_c.q7)) >>> 4;
            r14_tout <= r13_c.tout;

            r15_d2m  <= h2x * r14_d2;
            r15_d1   <= r14_d1;
            r15_d4   <= r14_d4;
            r15_tout <= r14_tout;

            r16_d3   <= r15_d1 * (r15_d2m >>> 10);
            r16_d4   <= r15_d4;
            r16_tout <= r15_tout;

            r17_d5m  <= e17 * e17;
            r17_d3   <= r16_d3;
            r17_d4   <= r16_d4;
            r17_tout <= r16_tout;

            r18_d6m  <= r17_d4 * (r17_d5m >>> 10);
            r18_d3   <= r17_d3;
            r18_tout <= r17_tout;

            r19_sum  <= r18_d3 + (r18_d6m >>> 1);
            r19_tout <= r18_tout;

            r20_hm   <= (r19_sum >>> 10) * HUM_SCALE;
            r20_tout <= r19_tout;
        end
    end

    assign hv = r20_hm >>> 12;

    always_comb begin
        if (hv > HUM_MAX) begin
            o_humidity_milli = HUM_MAX[16:0];
        end else if (hv < 32'sd0) begin
            o_humidity_milli = '0;
        end else begin
            o_humidity_milli = hv[16:0];
        end
    end

    assign o_valid             = r_v[14];
    assign o_temperature_centi = r20_tout;

endmodule

// ----- rtl/env_sensor_temp_hum_compensation.sv -----
// ---------------------------------------------------------------------------
// env_sensor_temp_hum_compensation
// integer temperature and humidity compensation of an environmental sensor
// ---------------------------------------------------------------------------
// use:
//   calibration words are written over the cfg channel (index 0..5, see the
//   package); indexes 6 and 7 are taken and dropped. write only while idle
//   each s_axis beat carries one raw temperature and one raw humidity reading;
//   each m_axis beat carries the compensated pair, one beat per input beat
//   a result beat passes through the twenty pipeline registers and the output register
//   throughput: one beat per cycle while the skid register is empty; the twenty
//   pipeline stages all advance together, so the rate is set by the common stage enable alone
//   the multiplier-deep stages and the divide-by-100 units (three stages each,
//   reciprocal multiply) set the pipeline length
//   reset (synchronous, active low) clears all calibration words to zero and
//   empties the pipeline; payload registers are left as they are
//   when m_axis_tready is low the output register holds its beat and one more
//   beat drops into a skid register; with the skid full the whole pipeline
//   freezes and s_axis_tready falls until the receiver takes the waiting beat
// ---------------------------------------------------------------------------
module env_sensor_temp_hum_compensation (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // cfg write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [envc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [envc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // sample stream in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [envc_pkg::AXIS_IN_W-1:0]     s_axis_tdata,  // raw_temperature[19:0], raw_humidity[35:20], zero pad
    // result stream out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [envc_pkg::AXIS_OUT_W-1:0]    m_axis_tdata   // temperature_centi[15:0], humidity_milli[32:16], zero pad
);
    import envc_pkg::*;

    t_cal               r_cal;
    logic               en;
    logic               temp_v, pipe_v;
    logic signed [31:0] temp_tc;
    logic [15:0]        temp_rh;
    logic [TEMP_W-1:0]  pipe_temp;
    logic [HUM_W-1:0]   pipe_hum;
    logic               r_o_v, r_s_v;
    logic [TEMP_W-1:0]  r_o_temp, r_s_temp;
    logic [HUM_W-1:0]   r_o_hum, r_s_hum;
    logic               out_free;

    // calibration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_CAL_ONE:   r_cal.t1    <= i_cfg_data[15:0];
                CFG_TEMP_CAL_TWO:   r_cal.t2    <= i_cfg_data[15:0];
                CFG_TEMP_CAL_THREE: r_cal.t3    <= i_cfg_data[7:0];
                CFG_HUM_CAL_ONE:    r_cal.h1    <= i_cfg_data[11:0];
                CFG_HUM_CAL_TWO:    r_cal.h2    <= i_cfg_data[11:0];
                CFG_HUM_CAL_REST:   r_cal.hrest <= i_cfg_data[39:0];
                default:            r_cal       <= r_cal;
            endcase
        end
    end

    // whole pipeline moves while the skid register is empty
    assign en            = !r_s_v;
    assign s_axis_tready = en;

    envc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_raw_t (s_axis_tdata[19:0]),
        .i_raw_h (s_axis_tdata[35:20]),
        .i_cal   (r_cal),
        .o_valid (temp_v),
        .o_tc    (temp_tc),
        .o_raw_h (temp_rh)
    );

    envc_hum u_hum (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (en),
        .i_valid             (temp_v),
        .i_tc                (temp_tc),
        .i_raw_h             (temp_rh),
        .i_cal               (r_cal),
        .o_valid             (pipe_v),
        .o_temperature_centi (pipe_temp),
        .o_humidity_milli    (pipe_hum)
    );

    // output register plus skid register
    assign out_free = m_axis_tready || !r_o_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (r_s_v) begin
            if (out_free) begin
                r_o_v <= 1'b1;
                r_s_v <= 1'b0;
            end
        end else if (out_free) begin
            r_o_v <= pipe_v;
        end else if (pipe_v) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_v) begin
            if (out_free) begin
                r_o_temp <= r_s_temp;
                r_o_hum  <= r_s_hum;
            end
        end else if (out_free) begin
            r_o_temp <= pipe_temp;
            r_o_hum  <= pipe_hum;
        end else begin
            r_s_temp <= pipe_temp;
            r_s_hum  <= pipe_hum;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {{(AXIS_OUT_W-TEMP_W-HUM_W){1'b0}}, r_o_hum, r_o_temp};

    // skid only ever holds a beat behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v |-> r_o_v)
        else $error("skid register full with output register empty");

    // skid fills only when the output beat was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s_v) |-> $past(r_o_v && !m_axis_tready))
        else $error("skid register filled without a stall");

    // humidity stays within the clamp range
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32:16] <= HUM_MAX[16:0]))
        else $error("humidity beyond clamp range");

endmodule

// ----- verif/envc_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// envc_checker
// watches the calibration, sample and result channels of the compensation
// block, works out the compensated pair for every sample beat taken and
// compares each result beat with the oldest pair still owed
// ---------------------------------------------------------------------------
module envc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [envc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [envc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [envc_pkg::AXIS_IN_W-1:0]    i_in_data,   // raw_temperature, raw_humidity, zero pad
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [envc_pkg::AXIS_OUT_W-1:0]   i_out_data,  // temperature_centi, humidity_milli, zero pad
    output int                                o_fail_count,
    output int                                o_pending
);
    import envc_pkg::*;

    localparam int PCT_DIV = 100;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
    } t_reading;

    logic [15:0] cal_t1;
    logic [15:0] cal_t2;
    logic [7:0]  cal_t3;
    logic [11:0] cal_h1;
    logic [11:0] cal_h2;
    logic [39:0] cal_rest;

    t_reading owed_readings [$];
    int       fail_cnt = 0;

    // all arithmetic in 32-bit int, so products and sums wrap by themselves
    function automatic t_reading compensate(input logic [RAW_T_W-1:0] raw_t,
                                            input logic [RAW_H_W-1:0] raw_h);
        int t_adc, h_adc, t1, t2, t3, h1, h2, h3, h4, h5, h6, h7;
        int a, b, c, half, fine, tc, tout;
        int d1, d2, d3, d4, d5, d6, hum;
        t_reading r;
        t_adc = int'(raw_t);
        h_adc = int'(raw_h);
        t1 = int'(cal_t1);
        t2 = int'($signed(cal_t2));
        t3 = int'($signed(cal_t3));
        h1 = int'(cal_h1);
        h2 = int'(cal_h2);
        h3 = int'($signed(cal_rest[7:0]));
        h4 = int'($signed(cal_rest[15:8]));
        h5 = int'($signed(cal_rest[23:16]));
        h6 = int'(cal_rest[31:24]);
        h7 = int'($signed(cal_rest[39:32]));

        a    = (t_adc >>> 3) - t1 * 2;
        b    = (a * t2) >>> 11;
        half = a >>> 1;
        c    = (((half * half) >>> 12) * (t3 * 16)) >>> 14;
        fine = b + c;
        tc   = (fine * 5 + TEMP_ROUND) >>> 8;
        tout = tc;
        if (tout > TEMP_MAX) tout = TEMP_MAX;
        if (tout < TEMP_MIN) tout = TEMP_MIN;

        // humidity takes the unsaturated temperature
        d1 = (h_adc - h1 * 16) - (((tc * h3) / PCT_DIV) >>> 1);
        d2 = (tc * h4) / PCT_DIV + (((tc * ((tc * h5) / PCT_DIV)) >>> 6) / PCT_DIV);
        d2 = d2 + HUM_OFFSET;
        d2 = (h2 * d2) >>> 10;
        d3 = d1 * d2;
        d4 = (h6 * 128 + (tc * h7) / PCT_DIV) >>> 4;
        d5 = ((d3 >>> 14) * (d3 >>> 14)) >>> 10;
        d6 = (d4 * d5) >>> 1;
        hum = (((d3 + d6) >>> 10) * HUM_SCALE) >>> 12;
        if (hum > HUM_MAX) hum = HUM_MAX;
        if (hum < 0) hum = 0;

        r.temp = tout[TEMP_W-1:0];
        r.hum  = hum[HUM_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        $display("envc_checker: %s", msg);
    endtask

    always @(posedge i_clk) begin
        t_reading got, want;
        if (!i_rst_n) begin
            cal_t1   = '0;
            cal_t2   = '0;
            cal_t3   = '0;
            cal_h1   = '0;
            cal_h2   = '0;
            cal_rest = '0;
            owed_readings.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TEMP_CAL_ONE:   cal_t1   = i_cfg_data[15:0];
                    CFG_TEMP_CAL_TWO:   cal_t2   = i_cfg_data[15:0];
                    CFG_TEMP_CAL_THREE: cal_t3   = i_cfg_data[7:0];
                    CFG_HUM_CAL_ONE:    cal_h1   = i_cfg_data[11:0];
                    CFG_HUM_CAL_TWO:    cal_h2   = i_cfg_data[11:0];
                    CFG_HUM_CAL_REST:   cal_rest = i_cfg_data[39:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.temp = i_out_data[TEMP_W-1:0];
                got.hum  = i_out_data[TEMP_W+HUM_W-1:TEMP_W];
                if (owed_readings.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing owed, temp %0d hum %0d",
                                              got.temp, got.hum));
                end else begin
                    want = owed_readings.pop_front();
                    if (got.temp !== want.temp)
                        report_mismatch($sformatf("temperature got %0d, predicted %0d",
                                                  got.temp, want.temp));
                    if (got.hum !== want.hum)
                        report_mismatch($sformatf("humidity got %0d, predicted %0d",
                                                  got.hum, want.hum));
                end
            end
            if (i_in_valid && i_in_ready)
                owed_readings.push_back(compensate(i_in_data[RAW_T_W-1:0],
                                                   i_in_data[RAW_T_W+RAW_H_W-1:RAW_T_W]));
        end
        o_pending    <= owed_readings.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// drives calibration words and raw sample beats into the compensation block
// over several calibration settings and idling patterns; the checker beside
// the block predicts every result and counts mismatches
// ---------------------------------------------------------------------------
module tb;
    import envc_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RST_CYCLES       = 11;
    localparam int LATENCY          = 21;
    localparam int HOLD_CYCLES      = 300;
    localparam int QUIET_LIMIT      = 4000;
    localparam int RANDOM_PER_PHASE = 55;
    localparam int NUM_PHASES       = 8;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [RAW_T_W-1:0] RAW_T_MAX = '1;
    localparam logic [RAW_H_W-1:0] RAW_H_MAX = '1;

    // directed grid: extremes plus two readings near room conditions
    localparam logic [RAW_T_W-1:0] GRID_T [4] = '{20'd0, 20'hFFFFF, 20'd400000, 20'd600000};
    localparam logic [RAW_H_W-1:0] GRID_H [4] = '{16'd0, 16'hFFFF, 16'd25000, 16'd45000};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idling;

    typedef enum int {
        PH_RESET_CAL,
        PH_TYPICAL,
        PH_MAX_CAL,
        PH_MIN_CAL,
        PH_BACKPRESSURE,
        PH_PAUSE,
        PH_RANDOM_A,
        PH_RANDOM_B
    } t_phase;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [AXIS_IN_W-1:0]   s_axis_tdata  = '0;  // raw_temperature[19:0], raw_humidity[35:20]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [AXIS_OUT_W-1:0]  m_axis_tdata;        // temperature_centi[15:0], humidity_milli[32:16]

    int fail_count;
    int pending;

    // idling knobs, percentage of cycles spent idle on each side
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off: main bumps hold_asked, the receiver process counts
    int hold_asked = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    int quiet_cycles = 0;
    logic beat_seen;

    always #(CLK_HALF) i_clk = ~i_clk;

    env_sensor_temp_hum_compensation u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    envc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // watchdog: any beat on any channel restarts the count
    assign beat_seen = (i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                       (m_axis_tvalid && m_axis_tready);

    always @(posedge i_clk) begin
        if (!i_rst_n || beat_seen) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 61;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 61;
            end
            default: begin
                send_idle_pct  = 31;
                recv_stall_pct = 31;
            end
        endcase
    endtask

    // one register beat; bits above the register width get random junk
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int width);
        logic [CFG_DATA_W-1:0] keep, junk;
        keep = (width >= CFG_DATA_W) ? '1 : ((40'd1 << width) - 40'd1);
        junk = 40'({$urandom, $urandom});
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= (value & keep) | (junk & ~keep);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // full calibration set, then a stray write past the register map
    task automatic program_cal(input logic [15:0] t1, input logic [15:0] t2,
                               input logic [7:0] t3, input logic [11:0] h1,
                               input logic [11:0] h2, input logic [39:0] hrest);
        cfg_write(CFG_TEMP_CAL_ONE,   40'(t1), 16);
        cfg_write(CFG_TEMP_CAL_TWO,   40'(t2), 16);
        cfg_write(CFG_TEMP_CAL_THREE, 40'(t3), 8);
        cfg_write(CFG_HUM_CAL_ONE,    40'(h1), 12);
        cfg_write(CFG_HUM_CAL_TWO,    40'(h2), 12);
        cfg_write(CFG_HUM_CAL_REST,   hrest,   40);
        cfg_write($urandom_range(1, 0) ? CFG_SPARE_LO : CFG_SPARE_HI, '0, 0);
        i_cfg_valid <= 1'b0;
    endtask

    // either a plausible factory set or fully random words
    task automatic program_random_cal();
        logic [39:0] hrest;
        hrest = 40'({$urandom, $urandom});
        if ($urandom_range(1, 0))
            program_cal(16'($urandom_range(28000, 24000)), 16'($urandom_range(27500, 25000)),
                        8'($urandom_range(10, 0) - 5), 12'($urandom_range(900, 500)),
                        12'($urandom_range(1100, 900)), hrest);
        else
            program_cal(16'($urandom), 16'($urandom), 8'($urandom), 12'($urandom),
                        12'($urandom), hrest);
    endtask

    // one sample beat, with random idle cycles ahead of it
    task automatic push_sample(input logic [RAW_T_W-1:0] raw_t, input logic [RAW_H_W-1:0] raw_h);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(AXIS_IN_W-RAW_T_W-RAW_H_W){1'b0}}, raw_h, raw_t};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // half near room conditions, half anywhere in the field range
    task automatic push_random_sample();
        logic [RAW_T_W-1:0] raw_t;
        logic [RAW_H_W-1:0] raw_h;
        if ($urandom_range(1, 0)) begin
            raw_t = RAW_T_W'($urandom_range(700000, 250000));
            raw_h = RAW_H_W'($urandom_range(55000, 15000));
        end else begin
            raw_t = RAW_T_W'($urandom);
            raw_h = RAW_H_W'($urandom);
        end
        push_sample(raw_t, raw_h);
    endtask

    task automatic push_corners();
        push_sample('0, '0);
        push_sample(RAW_T_MAX, RAW_H_MAX);
        push_sample('0, RAW_H_MAX);
        push_sample(RAW_T_MAX, '0);
    endtask

    // sender goes quiet until every owed result has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        t_phase phase;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            phase = t_phase'(p);
            set_idling(t_idling'(p % 4));
            case (phase)
                PH_RESET_CAL: ;  // calibration still all zero from reset
                PH_TYPICAL: begin
                    // h7 -100, h6 120, h5 20, h4 45, h3 0 from the top byte down
                    program_cal(16'd26000, 16'd26200, 8'd3, 12'd700, 12'd1010,
                                {8'h9C, 8'd120, 8'd20, 8'd45, 8'd0});
                    for (int i = 0; i < 4; i++)
                        for (int j = 0; j < 4; j++)
                            push_sample(GRID_T[i], GRID_H[j]);
                end
                PH_MAX_CAL: begin
                    program_cal(16'hFFFF, 16'h7FFF, 8'h7F, 12'hFFF, 12'hFFF,
                                {8'h7F, 8'hFF, 8'h7F, 8'h7F, 8'h7F});
                    push_corners();
                end
                PH_MIN_CAL: begin
                    program_cal(16'h0000, 16'h8000, 8'h80, 12'h000, 12'h000,
                                {8'h80, 8'h00, 8'h80, 8'h80, 8'h80});
                    push_corners();
                end
                PH_BACKPRESSURE: begin
                    program_random_cal();
                    // receiver holds off while the sender keeps offering, so the
                    // pipeline and skid fill and the input side stalls
                    hold_asked = hold_asked + 1;
                end
                default: program_random_cal();
            endcase

            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (phase == PH_PAUSE && k == RANDOM_PER_PHASE / 2)
                    drain();
                push_random_sample();
            end
            // idle before the next calibration write
            drain();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
